>>> src/wslf_pkg.sv
// wslf_pkg: shared constants, register indexes and phase codes of the waypoint follower
// used by the channel interfaces and the top level; no dependencies
package wslf_pkg;

    localparam int MAX_WAYPOINTS_DEF = 256;
    localparam int COORD_BITS_DEF    = 32;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int SL_W      = 31;
    localparam int AR_W      = 31;
    localparam int TH_W      = 32;
    localparam int PL_W      = 9;
    localparam int IDX_W     = 9;
    localparam int SLOT_W    = 8;
    localparam int PHASE_W   = 2;

    localparam logic [SL_W-1:0] SL_RST = 31'd131072;
    localparam logic [AR_W-1:0] AR_RST = 31'd13107;
    localparam logic [TH_W-1:0] TH_RST = 32'd196608;
    localparam logic [PL_W-1:0] PL_RST = 9'd0;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_LENGTH    = 2'd0,
        CFG_ARRIVE_RADIUS  = 2'd1,
        CFG_TAKEOFF_HEIGHT = 2'd2,
        CFG_PATH_LENGTH    = 2'd3
    } cfg_idx_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE    = 2'd0,
        PH_TAKEOFF = 2'd1,
        PH_FOLLOW  = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

endpackage

>>> src/wslf_item_if.sv
// wslf_item_if: input channel (load items and position samples)
// depends on wslf_pkg
interface wslf_item_if import wslf_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [SLOT_W-1:0]            slot;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;

    modport source (output valid, req_type, slot, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, req_type, slot, coord_x, coord_y, coord_z, output ready);
endinterface

>>> src/wslf_result_if.sv
// wslf_result_if: result channel (setpoint, phase, waypoint index)
// depends on wslf_pkg
interface wslf_result_if import wslf_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         publish;
    logic signed [COORD_BITS-1:0] set_x;
    logic signed [COORD_BITS-1:0] set_y;
    logic signed [COORD_BITS-1:0] set_z;
    logic [PHASE_W-1:0]           phase;
    logic [IDX_W-1:0]             current_waypoint;

    modport source (output valid, publish, set_x, set_y, set_z, phase, current_waypoint,
                    input ready);
    modport sink   (input valid, publish, set_x, set_y, set_z, phase, current_waypoint,
                    output ready);
endinterface

>>> src/waypoint_step_limited_follower.sv
// waypoint_step_limited_follower: step-limited waypoint setpoint generator, top level
// depends on wslf_pkg, wslf_item_if, wslf_result_if, wslf_ram
//
//   channel   dir  handshake     contents
//   cfg       in   cfg_we        cfg_idx, cfg_data (register write, no read-back)
//   item      in   valid/ready   req_type, slot, coord_x/y/z
//   result    out  valid/ready   publish, set_x/y/z, phase, current_waypoint
//
// one item at a time; a load writes the ram, a sample may step through read, difference,
// bit-serial squarer, compare, root, lane products, divide; T = max(COORD_BITS, 32) bits
// result sits in an output register; the next item is taken while it waits
// a stalled result holds the sequencer in its emit step until the register frees
// rst_n clears control and config registers; the waypoint ram is not cleared
module waypoint_step_limited_follower import wslf_pkg::*; #(
    parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data,
    wslf_item_if.sink            item,
    wslf_result_if.source        result
);
    localparam int CB   = COORD_BITS;
    localparam int TW   = (CB > TH_W) ? CB : TH_W;
    localparam int SW   = 2 * TW + 2;
    localparam int RSW  = TW + 3;
    localparam int NW   = TW + SL_W;
    localparam int CW   = (SW > 2 * SL_W) ? SW : 2 * SL_W;
    localparam int AW   = $clog2(MAX_WAYPOINTS);
    localparam int CNTW = $clog2(TW + 2);
    localparam int RW   = 3 * CB;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_READ = 11'b00000000010,
        S_DIFF = 11'b00000000100,
        S_SQ   = 11'b00000001000,
        S_CMP  = 11'b00000010000,
        S_SQRT = 11'b00000100000,
        S_ROOT = 11'b00001000000,
        S_MUL  = 11'b00010000000,
        S_DIV  = 11'b00100000000,
        S_FIN  = 11'b01000000000,
        S_EMIT = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [SL_W-1:0] sl_reg, sl_next;
    logic [AR_W-1:0] ar_reg, ar_next;
    logic [TH_W-1:0] th_reg, th_next;
    logic [PL_W-1:0] pl_reg, pl_next;
    logic [2*SL_W-1:0] sl2_reg;
    logic [2*AR_W-1:0] r2_reg;

    logic seen_reg, seen_next;
    logic done_reg, done_next;
    logic signed [CB-1:0] tox_reg, tox_next, toy_reg, toy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic to_mode_reg, to_mode_next;

    logic signed [TW-1:0] cur_reg [3];
    logic signed [TW-1:0] cur_next [3];
    logic signed [TW-1:0] tgt_reg [3];
    logic signed [TW-1:0] tgt_next [3];
    logic [TW-1:0] mag_reg [3];
    logic [TW-1:0] mag_next [3];
    logic [TW-1:0] mb_reg [3];
    logic [TW-1:0] mb_next [3];
    logic neg_reg [3];
    logic neg_next [3];
    logic [SW-1:0] acc_reg, acc_next;
    logic [SW-1:0] sq_reg, sq_next;
    logic [RSW-1:0] rem_reg, rem_next;
    logic [TW:0] root_reg, root_next;
    logic [TW-1:0] nlo_reg [3];
    logic [TW-1:0] nlo_next [3];
    logic [TW:0] drem_reg [3];
    logic [TW:0] drem_next [3];
    logic [TW-1:0] q_reg [3];
    logic [TW-1:0] q_next [3];
    logic [CNTW-1:0] cnt_reg, cnt_next;

    logic pub_reg, pub_next;
    logic [CB-1:0] set_reg [3];
    logic [CB-1:0] set_next [3];

    logic ov_reg, ov_next;
    logic o_pub_reg, o_pub_next;
    logic [CB-1:0] o_set_reg [3];
    logic [CB-1:0] o_set_next [3];
    logic [PHASE_W-1:0] o_phase_reg, o_phase_next;
    logic [IDX_W-1:0] o_idx_reg, o_idx_next;

    // datapath temporaries
    logic signed [TW:0] diff [3];
    logic [TW+1:0] sq_term;
    logic [RSW-1:0] remt, trial;
    logic [TW+1:0] dt [3];
    logic ge [3];
    logic [NW-1:0] prod;
    logic [1:0] lane;
    logic [IDX_W-1:0] used;
    phase_t phase_now;
    logic below_r2, below_sl2;
    logic accept;

    logic ram_we;
    logic [RW-1:0] ram_rdata;

    wslf_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_WAYPOINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(item.slot)),
        .wdata ({item.coord_z, item.coord_y, item.coord_x}),
        .raddr (AW'(idx_reg)),
        .rdata (ram_rdata)
    );

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign ram_we     = accept && (item.req_type == REQ_LOAD)
                        && (32'(item.slot) < MAX_WAYPOINTS);

    assign result.valid            = ov_reg;
    assign result.publish          = o_pub_reg;
    assign result.set_x            = o_set_reg[0];
    assign result.set_y            = o_set_reg[1];
    assign result.set_z            = o_set_reg[2];
    assign result.phase            = o_phase_reg;
    assign result.current_waypoint = o_idx_reg;

    assign used = (32'(pl_reg) > MAX_WAYPOINTS) ? IDX_W'(MAX_WAYPOINTS) : pl_reg;
    assign below_r2  = CW'(acc_reg) < CW'(r2_reg);
    assign below_sl2 = CW'(acc_reg) < CW'(sl2_reg);
    assign lane = cnt_reg[1:0];
    assign prod = NW'(mag_reg[lane] * sl_reg);

    always_comb
    begin
        if (!seen_reg)
            phase_now = PH_IDLE;
        else if (!done_reg)
            phase_now = PH_TAKEOFF;
        else if (idx_reg < used)
            phase_now = PH_FOLLOW;
        else
            phase_now = PH_DONE;
    end

    always_comb
    begin
        sq_term = '0;
        for (int k = 0; k < 3; k++)
        begin
            diff[k] = (TW+1)'(tgt_reg[k]) - (TW+1)'(cur_reg[k]);
            if (mb_reg[k][TW-1])
                sq_term = sq_term + (TW+2)'(mag_reg[k]);
            dt[k] = {drem_reg[k], nlo_reg[k][TW-1]};
            ge[k] = dt[k] >= (TW+2)'(root_reg);
        end
        remt  = {rem_reg[RSW-3:0], sq_reg[SW-1 -: 2]};
        trial = {root_reg, 2'b01};
    end

    // config writes
    always_comb
    begin
        sl_next = sl_reg;
        ar_next = ar_reg;
        th_next = th_reg;
        pl_next = pl_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_STEP_LENGTH:    sl_next = cfg_data[SL_W-1:0];
                CFG_ARRIVE_RADIUS:  ar_next = cfg_data[AR_W-1:0];
                CFG_TAKEOFF_HEIGHT: th_next = cfg_data[TH_W-1:0];
                CFG_PATH_LENGTH:    pl_next = cfg_data[PL_W-1:0];
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        seen_next    = seen_reg;
        done_next    = done_reg;
        tox_next     = tox_reg;
        toy_next     = toy_reg;
        idx_next     = idx_reg;
        to_mode_next = to_mode_reg;
        acc_next     = acc_reg;
        sq_next      = sq_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        cnt_next     = cnt_reg;
        pub_next     = pub_reg;
        o_pub_next   = o_pub_reg;
        o_phase_next = o_phase_reg;
        o_idx_next   = o_idx_reg;
        ov_next      = ov_reg && !result.ready;
        for (int k = 0; k < 3; k++)
        begin
            cur_next[k]   = cur_reg[k];
            tgt_next[k]   = tgt_reg[k];
            mag_next[k]   = mag_reg[k];
            mb_next[k]    = mb_reg[k];
            neg_next[k]   = neg_reg[k];
            nlo_next[k]   = nlo_reg[k];
            drem_next[k]  = drem_reg[k];
            q_next[k]     = q_reg[k];
            set_next[k]   = set_reg[k];
            o_set_next[k] = o_set_reg[k];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    pub_next = 1'b0;
                    for (int k = 0; k < 3; k++)
                        set_next[k] = '0;
                    if (item.req_type == REQ_LOAD)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cur_next[0] = TW'(item.coord_x);
                        cur_next[1] = TW'(item.coord_y);
                        cur_next[2] = TW'(item.coord_z);
                        if (!seen_reg)
                        begin
                            seen_next = 1'b1;
                            tox_next  = item.coord_x;
                            toy_next  = item.coord_y;
                        end
                        if (!done_reg)
                        begin
                            to_mode_next = 1'b1;
                            tgt_next[0]  = seen_reg ? TW'(tox_reg) : TW'(item.coord_x);
                            tgt_next[1]  = seen_reg ? TW'(toy_reg) : TW'(item.coord_y);
                            tgt_next[2]  = TW'($signed(th_reg));
                            state_next   = S_DIFF;
                        end
                        else if (idx_reg < used)
                        begin
                            to_mode_next = 1'b0;
                            state_next   = S_READ;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                end
            end
            S_READ:
            begin
                tgt_next[0] = TW'($signed(ram_rdata[CB-1:0]));
                tgt_next[1] = TW'($signed(ram_rdata[2*CB-1:CB]));
                tgt_next[2] = TW'($signed(ram_rdata[3*CB-1:2*CB]));
                state_next  = S_DIFF;
            end
            S_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    neg_next[k] = diff[k][TW];
                    mag_next[k] = diff[k][TW] ? TW'(-diff[k]) : TW'(diff[k]);
                    mb_next[k]  = diff[k][TW] ? TW'(-diff[k]) : TW'(diff[k]);
                end
                acc_next   = '0;
                cnt_next   = '0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                // msb-first shift-add squarer, all three components share one accumulator
                acc_next = (acc_reg << 1) + SW'(sq_term);
                for (int k = 0; k < 3; k++)
                    mb_next[k] = mb_reg[k] << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(TW - 1))
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                if (below_r2)
                begin
                    if (to_mode_reg)
                        done_next = 1'b1;
                    else
                        idx_next = idx_reg + 1'b1;
                    state_next = S_EMIT;
                end
                else if (to_mode_reg || below_sl2)
                begin
                    pub_next = 1'b1;
                    for (int k = 0; k < 3; k++)
                        set_next[k] = tgt_reg[k][CB-1:0];
                    state_next = S_EMIT;
                end
                else
                begin
                    sq_next    = acc_reg;
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                // restoring root, two radicand bits per cycle
                sq_next = sq_reg << 2;
                if (remt >= trial)
                begin
                    rem_next  = remt - trial;
                    root_next = {root_reg[TW-1:0], 1'b1};
                end
                else
                begin
                    rem_next  = remt;
                    root_next = {root_reg[TW-1:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(TW))
                    state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (root_reg == '0)
                begin
                    pub_next = 1'b1;
                    for (int k = 0; k < 3; k++)
                        set_next[k] = tgt_reg[k][CB-1:0];
                    state_next = S_EMIT;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // one lane product per cycle; quotient fits T bits so the top starts the remainder
                drem_next[lane] = (TW+1)'(prod[NW-1:TW]);
                nlo_next[lane]  = prod[TW-1:0];
                q_next[lane]    = '0;
                if (lane == 2'd2)
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    drem_next[k] = ge[k] ? (TW+1)'(dt[k] - (TW+2)'(root_reg)) : dt[k][TW:0];
                    q_next[k]    = {q_reg[k][TW-2:0], ge[k]};
                    nlo_next[k]  = nlo_reg[k] << 1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(TW - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                pub_next = 1'b1;
                for (int k = 0; k < 3; k++)
                begin
                    if (neg_reg[k])
                        set_next[k] = CB'((TW+1)'(cur_reg[k]) - (TW+1)'(q_reg[k]));
                    else
                        set_next[k] = CB'((TW+1)'(cur_reg[k]) + (TW+1)'(q_reg[k]));
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!ov_reg || result.ready)
                begin
                    ov_next      = 1'b1;
                    o_pub_next   = pub_reg;
                    o_phase_next = phase_now;
                    o_idx_next   = idx_reg;
                    for (int k = 0; k < 3; k++)
                        o_set_next[k] = set_reg[k];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sl_reg    <= SL_RST;
            ar_reg    <= AR_RST;
            th_reg    <= TH_RST;
            pl_reg    <= PL_RST;
            seen_reg  <= 1'b0;
            done_reg  <= 1'b0;
            tox_reg   <= '0;
            toy_reg   <= '0;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sl_reg    <= sl_next;
            ar_reg    <= ar_next;
            th_reg    <= th_next;
            pl_reg    <= pl_next;
            seen_reg  <= seen_next;
            done_reg  <= done_next;
            tox_reg   <= tox_next;
            toy_reg   <= toy_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sl2_reg     <= (2*SL_W)'(sl_reg * sl_reg);
        r2_reg      <= (2*AR_W)'(ar_reg * ar_reg);
        to_mode_reg <= to_mode_next;
        acc_reg     <= acc_next;
        sq_reg      <= sq_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        cnt_reg     <= cnt_next;
        pub_reg     <= pub_next;
        o_pub_reg   <= o_pub_next;
        o_phase_reg <= o_phase_next;
        o_idx_reg   <= o_idx_next;
        for (int k = 0; k < 3; k++)
        begin
            cur_reg[k]   <= cur_next[k];
            tgt_reg[k]   <= tgt_next[k];
            mag_reg[k]   <= mag_next[k];
            mb_reg[k]    <= mb_next[k];
            neg_reg[k]   <= neg_next[k];
            nlo_reg[k]   <= nlo_next[k];
            drem_reg[k]  <= drem_next[k];
            q_reg[k]     <= q_next[k];
            set_reg[k]   <= set_next[k];
            o_set_reg[k] <= o_set_next[k];
        end
    end

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !item.ready)
        else $error("item taken while a transaction is in flight");

    a_pub_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.publish) |-> (result.phase != PH_IDLE))
        else $error("setpoint published before any sample");

    a_idx_takeoff: assert property (@(posedge clk) disable iff (!rst_n)
        !done_reg |-> (idx_reg == '0))
        else $error("waypoint index moved during take-off");

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && (!ov_reg || result.ready)) |=> result.valid)
        else $error("result lost at emit");

endmodule

>>> src/wslf_ram.sv
// wslf_ram: generic single-clock ram, one write port, one registered read port
// no dependencies
module wslf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
